// ===== design/palette_nearest_color_search_macros.svh =====
// Assertion macros shared by the palette search RTL.
// Expects clk and rst_n in the scope of each use; no other dependencies.
`ifndef PALETTE_NEAREST_COLOR_SEARCH_MACROS_SVH
`define PALETTE_NEAREST_COLOR_SEARCH_MACROS_SVH

// same-cycle implication
`define PNCS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PNCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/pncs_pkg.sv =====
// Package for the palette nearest color search: widths, codes, color space
// coefficients and the controller/datapath command and status structs.
// No dependencies.
`default_nettype none

package pncs_pkg;

  localparam int PALETTE_DEPTH_DEFAULT = 256;

  localparam int COUNT_W = 9;
  localparam int COEF_W  = 17;
  localparam int DIFF_W  = 9;
  localparam int PROD_W  = COEF_W + DIFF_W;
  localparam int SQ_FULL_W = 2 * PROD_W;
  localparam int SQ_W    = 50;
  localparam int DIST_W  = 52;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic CFG_IDX_COUNT = 1'b0;
  localparam logic CFG_IDX_MODE  = 1'b1;

  // Q2.15 coefficients [mode][row][column], columns r, g, b
  localparam logic signed [COEF_W-1:0] COEF_TABLE [4][3][3] = '{
    '{ '{ 17'sd32768,  17'sd0,      17'sd0     },
       '{ 17'sd0,      17'sd32768,  17'sd0     },
       '{ 17'sd0,      17'sd0,      17'sd32768 } },
    '{ '{ 17'sd9798,   17'sd19235,  17'sd3736  },
       '{ -17'sd5529,  -17'sd10855, 17'sd16384 },
       '{ 17'sd16384,  -17'sd13720, -17'sd2664 } },
    '{ '{ 17'sd9798,   17'sd19235,  17'sd3736  },
       '{ 17'sd19520,  -17'sd8993,  -17'sd10527 },
       '{ 17'sd6929,   -17'sd17124, 17'sd10202 } },
    '{ '{ 17'sd9798,   17'sd19235,  17'sd3736  },
       '{ -17'sd4820,  -17'sd9464,  17'sd14284 },
       '{ 17'sd20375,  -17'sd17061, -17'sd3313 } }
  };

  typedef struct packed {
    logic write;
    logic capture;
    logic issue;
    logic first;
    logic last;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic found;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ===== design/palette_nearest_color_search.sv =====
// Palette nearest color search, top level: configuration registers and the
// controller and datapath instances. Depends on pncs_pkg, pncs_ctrl,
// pncs_datapath.
//
// Use: the input channel (in_valid / in_stall) carries load beats (in_kind 0)
// that write one palette entry and give no result, and query beats (in_kind 1)
// that return one result beat on the out_ channel: the index and color of the
// palette entry nearest to the query pixel among the first palette_count
// entries, in the color space chosen by the mode register.
// A load writes its entry when accepted and does not stall the input. A query
// sweeps n entries, one per cycle through the single palette read port and
// distance pipeline, n = min(palette_count, PALETTE_DEPTH), or 1 for alpha zero
// or a count of zero; its result is registered once the sweep has drained and
// the output register is free, and the next beat is taken after that.
// The result sits in an output register, so a stalled receiver holds only
// that beat; loads and the next query proceed until a second result is due.
// The cfg_ channel is always ready; write it only while the block is idle.
// Reset clears the control state, sets palette_count to 1 and the color
// space to rgb. Palette contents are undefined until loaded.
`default_nettype none

module palette_nearest_color_search #(
  parameter int PALETTE_DEPTH = pncs_pkg::PALETTE_DEPTH_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         in_kind,
  input  wire logic [7:0]                   in_entry_index,
  input  wire logic [7:0]                   in_pixel_red,
  input  wire logic [7:0]                   in_pixel_green,
  input  wire logic [7:0]                   in_pixel_blue,
  input  wire logic [7:0]                   in_pixel_alpha,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [7:0]                        out_match_index,
  output logic [7:0]                        out_match_red,
  output logic [7:0]                        out_match_green,
  output logic [7:0]                        out_match_blue,
  output logic [7:0]                        out_match_alpha,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic                         cfg_index,
  input  wire logic [pncs_pkg::COUNT_W-1:0] cfg_data
);

  localparam int ADDR_W = $clog2(PALETTE_DEPTH);
  localparam int CNT_W  = $clog2(PALETTE_DEPTH + 1);

  logic [pncs_pkg::COUNT_W-1:0] palette_count_r;
  logic [1:0]                   space_sel_r;
  pncs_pkg::cmd_t               cmd;
  pncs_pkg::status_t            status;
  logic [ADDR_W-1:0]            rd_addr;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      palette_count_r <= pncs_pkg::COUNT_W'(1);
      space_sel_r     <= 2'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pncs_pkg::CFG_IDX_COUNT: begin
          palette_count_r <= cfg_data;
        end
        pncs_pkg::CFG_IDX_MODE: begin
          space_sel_r <= cfg_data[1:0];
        end
        default: begin
        end
      endcase
    end
  end

  pncs_ctrl #(
    .DEPTH  (PALETTE_DEPTH),
    .ADDR_W (ADDR_W),
    .CNT_W  (CNT_W)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_pixel_alpha (in_pixel_alpha),
    .palette_count  (palette_count_r),
    .cmd            (cmd),
    .rd_addr        (rd_addr),
    .status         (status)
  );

  pncs_datapath #(
    .DEPTH  (PALETTE_DEPTH),
    .ADDR_W (ADDR_W),
    .CNT_W  (CNT_W)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .rd_addr         (rd_addr),
    .space_sel       (space_sel_r),
    .in_entry_index  (in_entry_index),
    .in_pixel_red    (in_pixel_red),
    .in_pixel_green  (in_pixel_green),
    .in_pixel_blue   (in_pixel_blue),
    .in_pixel_alpha  (in_pixel_alpha),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_match_index (out_match_index),
    .out_match_red   (out_match_red),
    .out_match_green (out_match_green),
    .out_match_blue  (out_match_blue),
    .out_match_alpha (out_match_alpha)
  );

endmodule

`default_nettype wire

// ===== design/pncs_ctrl.sv =====
// Controller for the palette search: accepts beats, sequences the entry
// sweep and hands the result to the output register.
// Depends on pncs_pkg and palette_nearest_color_search_macros.svh.
`default_nettype none
`include "palette_nearest_color_search_macros.svh"

module pncs_ctrl #(
  parameter int DEPTH  = pncs_pkg::PALETTE_DEPTH_DEFAULT,
  parameter int ADDR_W = $clog2(DEPTH),
  parameter int CNT_W  = $clog2(DEPTH + 1)
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         in_kind,
  input  wire logic [7:0]                   in_pixel_alpha,
  input  wire logic [pncs_pkg::COUNT_W-1:0] palette_count,
  output pncs_pkg::cmd_t                    cmd,
  output logic [ADDR_W-1:0]                 rd_addr,
  input  wire pncs_pkg::status_t            status
);

  localparam int CMP_W = (CNT_W > pncs_pkg::COUNT_W) ? CNT_W : pncs_pkg::COUNT_W;

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_SEARCH  = 2'd1;
  localparam logic [1:0] ST_DRAIN   = 2'd2;
  localparam logic [1:0] ST_PUBLISH = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [ADDR_W-1:0] last_addr_r, last_addr_nxt;
  logic [CMP_W-1:0]  count_ext;
  logic [CNT_W-1:0]  span;
  logic              accept;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign rd_addr  = addr_r;
  assign count_ext = CMP_W'(palette_count);

  always_comb begin
    if (in_pixel_alpha == 8'd0 || palette_count == '0) begin
      span = CNT_W'(1);
    end else if (count_ext > CMP_W'(DEPTH)) begin
      span = CNT_W'(DEPTH);
    end else begin
      span = CNT_W'(count_ext);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    last_addr_nxt = last_addr_r;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_kind == pncs_pkg::KIND_LOAD) begin
            cmd.write = 1'b1;
          end else begin
            cmd.capture   = 1'b1;
            addr_nxt      = '0;
            last_addr_nxt = ADDR_W'(span - CNT_W'(1));
            state_nxt     = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        cmd.issue = 1'b1;
        cmd.first = (addr_r == '0);
        cmd.last  = (addr_r == last_addr_r);
        if (addr_r == last_addr_r) begin
          state_nxt = ST_DRAIN;
        end else begin
          addr_nxt = addr_r + ADDR_W'(1);
        end
      end
      ST_DRAIN: begin
        if (status.found) begin
          state_nxt = ST_PUBLISH;
        end
      end
      ST_PUBLISH: begin
        if (status.out_free) begin
          cmd.publish = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    addr_r      <= addr_nxt;
    last_addr_r <= last_addr_nxt;
  end

  `PNCS_ASSERT_NOW(a_publish_space, cmd.publish, status.out_free, "publish without space")
  `PNCS_ASSERT_NEXT(a_sweep_ends, cmd.issue && cmd.last, !cmd.issue, "sweep runs past last")
  `PNCS_ASSERT_NOW(a_found_drain, status.found, state_r == ST_DRAIN, "result outside drain")

endmodule

`default_nettype wire

// ===== design/pncs_datapath.sv =====
// Datapath for the palette search: palette memory, distance pipeline,
// running minimum and output register.
// Depends on pncs_pkg and palette_nearest_color_search_macros.svh.
`default_nettype none
`include "palette_nearest_color_search_macros.svh"

module pncs_datapath #(
  parameter int DEPTH  = pncs_pkg::PALETTE_DEPTH_DEFAULT,
  parameter int ADDR_W = $clog2(DEPTH),
  parameter int CNT_W  = $clog2(DEPTH + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire pncs_pkg::cmd_t    cmd,
  output pncs_pkg::status_t      status,
  input  wire logic [ADDR_W-1:0] rd_addr,
  input  wire logic [1:0]        space_sel,
  input  wire logic [7:0]        in_entry_index,
  input  wire logic [7:0]        in_pixel_red,
  input  wire logic [7:0]        in_pixel_green,
  input  wire logic [7:0]        in_pixel_blue,
  input  wire logic [7:0]        in_pixel_alpha,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [7:0]             out_match_index,
  output logic [7:0]             out_match_red,
  output logic [7:0]             out_match_green,
  output logic [7:0]             out_match_blue,
  output logic [7:0]             out_match_alpha
);

  localparam int EW = (CNT_W > 8) ? CNT_W : 8;

  typedef struct packed {
    logic              valid;
    logic              first;
    logic              last;
    logic [ADDR_W-1:0] idx;
    logic [31:0]       word;
  } tag_t;

  logic [31:0] mem [DEPTH];

  logic        wr_en;
  logic [7:0]  px_r [3];
  logic [31:0] rd_word_r;
  tag_t        tag_a_r, tag_b_r, tag_c_r, tag_d_r, tag_e_r;

  logic signed [pncs_pkg::DIFF_W-1:0] diff [3];
  logic signed [pncs_pkg::PROD_W-1:0] prod_nxt [3][3];
  logic signed [pncs_pkg::PROD_W-1:0] prod_r [3][3];
  logic signed [pncs_pkg::PROD_W-1:0] acc_r [3];
  logic signed [pncs_pkg::SQ_FULL_W-1:0] sq_full [3];
  logic [pncs_pkg::SQ_W-1:0]   sq_r [3];
  logic [pncs_pkg::DIST_W-1:0] dist_r;

  logic [pncs_pkg::DIST_W-1:0] best_dist_r;
  logic [ADDR_W-1:0]           best_idx_r;
  logic [31:0]                 best_word_r;
  logic                        found_r;
  logic                        out_valid_r;
  logic [7:0]                  out_index_r;
  logic [31:0]                 out_word_r;

  assign wr_en = cmd.write && (EW'(in_entry_index) < EW'(DEPTH));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[ADDR_W'(in_entry_index)] <= {in_pixel_alpha, in_pixel_blue,
                                       in_pixel_green, in_pixel_red};
    end
    if (cmd.issue) begin
      rd_word_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      px_r[0] <= in_pixel_red;
      px_r[1] <= in_pixel_green;
      px_r[2] <= in_pixel_blue;
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      diff[c] = $signed({1'b0, px_r[c]}) - $signed({1'b0, rd_word_r[8*c +: 8]});
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_nxt[r][c] = pncs_pkg::COEF_TABLE[space_sel][r][c] * diff[c];
      end
    end
    for (int r = 0; r < 3; r++) begin
      sq_full[r] = acc_r[r] * acc_r[r];
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    for (int r = 0; r < 3; r++) begin
      acc_r[r] <= prod_r[r][0] + prod_r[r][1] + prod_r[r][2];
      sq_r[r]  <= sq_full[r][pncs_pkg::SQ_W-1:0];
    end
    dist_r <= pncs_pkg::DIST_W'(sq_r[0]) + pncs_pkg::DIST_W'(sq_r[1])
            + pncs_pkg::DIST_W'(sq_r[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_a_r.valid <= 1'b0;
      tag_b_r.valid <= 1'b0;
      tag_c_r.valid <= 1'b0;
      tag_d_r.valid <= 1'b0;
      tag_e_r.valid <= 1'b0;
    end else begin
      tag_a_r.valid <= cmd.issue;
      tag_b_r.valid <= tag_a_r.valid;
      tag_c_r.valid <= tag_b_r.valid;
      tag_d_r.valid <= tag_c_r.valid;
      tag_e_r.valid <= tag_d_r.valid;
    end
    tag_a_r.first <= cmd.first;
    tag_a_r.last  <= cmd.last;
    tag_a_r.idx   <= rd_addr;
    tag_a_r.word  <= '0;
    tag_b_r.first <= tag_a_r.first;
    tag_b_r.last  <= tag_a_r.last;
    tag_b_r.idx   <= tag_a_r.idx;
    tag_b_r.word  <= rd_word_r;
    tag_c_r.first <= tag_b_r.first;
    tag_c_r.last  <= tag_b_r.last;
    tag_c_r.idx   <= tag_b_r.idx;
    tag_c_r.word  <= tag_b_r.word;
    tag_d_r.first <= tag_c_r.first;
    tag_d_r.last  <= tag_c_r.last;
    tag_d_r.idx   <= tag_c_r.idx;
    tag_d_r.word  <= tag_c_r.word;
    tag_e_r.first <= tag_d_r.first;
    tag_e_r.last  <= tag_d_r.last;
    tag_e_r.idx   <= tag_d_r.idx;
    tag_e_r.word  <= tag_d_r.word;
  end

  // strict less-than keeps the lowest index on ties
  always_ff @(posedge clk) begin
    if (tag_e_r.valid && (tag_e_r.first || dist_r < best_dist_r)) begin
      best_dist_r <= dist_r;
      best_idx_r  <= tag_e_r.idx;
      best_word_r <= tag_e_r.word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      found_r <= tag_e_r.valid && tag_e_r.last;
      if (cmd.publish) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    if (cmd.publish) begin
      out_index_r <= 8'(best_idx_r);
      out_word_r  <= best_word_r;
    end
  end

  assign status.found    = found_r;
  assign status.out_free = !out_valid_r || !out_stall;

  assign out_valid       = out_valid_r;
  assign out_match_index = out_index_r;
  assign out_match_red   = out_word_r[7:0];
  assign out_match_green = out_word_r[15:8];
  assign out_match_blue  = out_word_r[23:16];
  assign out_match_alpha = out_word_r[31:24];

  `PNCS_ASSERT_NEXT(a_publish_loads, cmd.publish, out_valid_r, "publish lost")
  `PNCS_ASSERT_NOW(a_capture_empty, cmd.capture,
    !(tag_a_r.valid || tag_b_r.valid || tag_c_r.valid || tag_d_r.valid || tag_e_r.valid),
    "query captured while sweep in flight")
  `PNCS_ASSERT_NOW(a_first_leads, tag_e_r.valid && !tag_e_r.first, $past(tag_e_r.valid),
    "sweep entry without predecessor")

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for palette_nearest_color_search: drives load and
// query beats, predicts the nearest palette entry per query and checks results.
// Depends on pncs_pkg and the palette_nearest_color_search RTL.
`timescale 1ns / 100ps

module tb;

  localparam int DEPTH = pncs_pkg::PALETTE_DEPTH_DEFAULT;
  localparam int SETTLE_CYCLES = 16;
  localparam int STALL_LIMIT = 5000;
  localparam int MAX_REPORTS = 10;

  // Q2.15 color transforms, row major, columns r g b
  localparam int COLOR_XFORM [4][9] = '{
    '{32768, 0, 0, 0, 32768, 0, 0, 0, 32768},
    '{9798, 19235, 3736, -5529, -10855, 16384, 16384, -13720, -2664},
    '{9798, 19235, 3736, 19520, -8993, -10527, 6929, -17124, 10202},
    '{9798, 19235, 3736, -4820, -9464, 14284, 20375, -17061, -3313}
  };

  typedef enum logic [1:0] {SPACE_RGB, SPACE_YCBCR, SPACE_YIQ, SPACE_YUV} space_t;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgba_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] slot;
    rgba_t      color;
  } beat_t;

  typedef struct packed {
    logic [7:0] index;
    rgba_t      color;
  } match_t;

  class palette_tracker;
    rgba_t      palette [DEPTH];
    bit         loaded [DEPTH];
    logic [8:0] count_reg;
    space_t     space_reg;
    match_t     pending_matches [$];
    int         errors;

    function new();
      count_reg = 9'd1;
      space_reg = SPACE_RGB;
      errors = 0;
      foreach (loaded[i]) begin
        loaded[i] = 1'b0;
        palette[i] = '0;
      end
    endfunction

    function int searched();
      if (count_reg == 0) return 1;
      if (count_reg > DEPTH) return DEPTH;
      return int'(count_reg);
    endfunction

    function longint color_distance(rgba_t q, rgba_t e);
      longint diff [3];
      longint acc;
      longint total;
      diff[0] = longint'(q.red) - longint'(e.red);
      diff[1] = longint'(q.green) - longint'(e.green);
      diff[2] = longint'(q.blue) - longint'(e.blue);
      total = 0;
      for (int k = 0; k < 3; k++) begin
        acc = 0;
        for (int j = 0; j < 3; j++)
          acc += longint'(COLOR_XFORM[int'(space_reg)][3*k+j]) * diff[j];
        total += acc * acc;
      end
      return total;
    endfunction

    function match_t nearest_entry(rgba_t q);
      int     best;
      longint best_dist;
      longint gap;
      match_t m;
      best = 0;
      if (q.alpha != 0) begin
        best_dist = color_distance(q, palette[0]);
        for (int i = 1; i < searched(); i++) begin
          gap = color_distance(q, palette[i]);
          if (gap < best_dist) begin
            best_dist = gap;
            best = i;
          end
        end
      end
      m.index = best[7:0];
      m.color = palette[best];
      return m;
    endfunction

    function void absorb_beat(beat_t b);
      if (b.kind == pncs_pkg::KIND_LOAD) begin
        palette[b.slot] = b.color;
        loaded[b.slot] = 1'b1;
      end else begin
        pending_matches.push_back(nearest_entry(b.color));
      end
    endfunction

    function void match_result(match_t got);
      match_t want;
      if (pending_matches.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected result beat: index %0d rgba %h", got.index, got.color);
        return;
      end
      want = pending_matches.pop_front();
      if (got.index !== want.index || got.color.red !== want.color.red ||
          got.color.green !== want.color.green || got.color.blue !== want.color.blue ||
          got.color.alpha !== want.color.alpha) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("result mismatch: expected index %0d rgba %h, got index %0d rgba %h",
                   want.index, want.color, got.index, got.color);
      end
    endfunction
  endclass

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_stall;
  logic                         in_kind;
  logic [7:0]                   in_entry_index;
  logic [7:0]                   in_pixel_red;
  logic [7:0]                   in_pixel_green;
  logic [7:0]                   in_pixel_blue;
  logic [7:0]                   in_pixel_alpha;
  logic                         out_valid;
  logic                         out_stall;
  logic [7:0]                   out_match_index;
  logic [7:0]                   out_match_red;
  logic [7:0]                   out_match_green;
  logic [7:0]                   out_match_blue;
  logic [7:0]                   out_match_alpha;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic                         cfg_index;
  logic [pncs_pkg::COUNT_W-1:0] cfg_data;

  palette_tracker sb;
  int send_idle_pct = 15;
  int recv_idle_pct = 79;
  int idle_cycles = 0;

  palette_nearest_color_search dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_entry_index  (in_entry_index),
    .in_pixel_red    (in_pixel_red),
    .in_pixel_green  (in_pixel_green),
    .in_pixel_blue   (in_pixel_blue),
    .in_pixel_alpha  (in_pixel_alpha),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_match_index (out_match_index),
    .out_match_red   (out_match_red),
    .out_match_green (out_match_green),
    .out_match_blue  (out_match_blue),
    .out_match_alpha (out_match_alpha),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.match_result({out_match_index, out_match_alpha, out_match_blue,
                       out_match_green, out_match_red});
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic rgba_t rgba(int red, int green, int blue, int alpha);
    return {alpha[7:0], blue[7:0], green[7:0], red[7:0]};
  endfunction

  function automatic logic [7:0] nudge(logic [7:0] v);
    int t;
    t = int'(v) + int'($urandom_range(8)) - 4;
    if (t < 0) t = 0;
    if (t > 255) t = 255;
    return t[7:0];
  endfunction

  task automatic drive_beat(beat_t b);
    in_valid <= 1'b1;
    in_kind <= b.kind;
    in_entry_index <= b.slot;
    in_pixel_red <= b.color.red;
    in_pixel_green <= b.color.green;
    in_pixel_blue <= b.color.blue;
    in_pixel_alpha <= b.color.alpha;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.absorb_beat(b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic load_entry(int slot, rgba_t c);
    drive_beat({pncs_pkg::KIND_LOAD, slot[7:0], c});
  endtask

  task automatic query_pixel(rgba_t c);
    logic [7:0] slot;
    slot = $urandom_range(255);
    drive_beat({pncs_pkg::KIND_QUERY, slot, c});
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending_matches.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(int count, space_t space);
    cfg_valid <= 1'b1;
    cfg_index <= pncs_pkg::CFG_IDX_COUNT;
    cfg_data <= count[8:0];
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.count_reg = count[8:0];
    cfg_index <= pncs_pkg::CFG_IDX_MODE;
    cfg_data <= {7'd0, space};
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.space_reg = space;
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(int count, space_t space, int items);
    int    span;
    int    slot;
    rgba_t c;
    wait_drained();
    write_config(count, space);
    for (int i = 0; i < sb.searched(); i++)
      if (!sb.loaded[i]) load_entry(i, rgba_t'($urandom));
    for (int n = 0; n < items; n++) begin
      if (n == items / 2) wait_drained();
      span = sb.searched();
      if ($urandom_range(99) < 30) begin
        slot = ($urandom_range(99) < 70) ? $urandom_range(span - 1) : $urandom_range(255);
        if ($urandom_range(99) < 20)
          c = sb.palette[$urandom_range(span - 1)];
        else
          c = rgba_t'($urandom);
        load_entry(slot, c);
      end else begin
        c = rgba_t'($urandom);
        case ($urandom_range(9))
          0: c = sb.palette[$urandom_range(span - 1)];
          1, 2: begin
            c = sb.palette[$urandom_range(span - 1)];
            c.red = nudge(c.red);
            c.green = nudge(c.green);
            c.blue = nudge(c.blue);
          end
          default: ;
        endcase
        c.alpha = ($urandom_range(99) < 6) ? 8'd0 : 8'($urandom_range(255));
        query_pixel(c);
      end
    end
  endtask

  initial begin
    int cnt;
    sb = new();
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_kind <= pncs_pkg::KIND_LOAD;
    in_entry_index <= '0;
    in_pixel_red <= '0;
    in_pixel_green <= '0;
    in_pixel_blue <= '0;
    in_pixel_alpha <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= pncs_pkg::CFG_IDX_COUNT;
    cfg_data <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset config: one entry searched, rgb
    load_entry(0, rgba(10, 20, 30, 40));
    query_pixel(rgba(0, 0, 0, 255));
    query_pixel(rgba(255, 255, 255, 0));
    wait_drained();
    write_config(4, SPACE_RGB);
    load_entry(1, rgba(255, 255, 255, 255));
    load_entry(2, rgba(0, 0, 0, 0));
    load_entry(3, rgba(255, 255, 255, 255));
    load_entry(255, rgba(8'hAA, 8'h55, 8'hAA, 8'h55));
    query_pixel(rgba(255, 255, 255, 1));
    query_pixel(rgba(0, 0, 0, 255));
    query_pixel(rgba(200, 0, 100, 128));
    wait_drained();
    write_config(0, SPACE_RGB);
    query_pixel(rgba(255, 255, 255, 255));
    for (int m = 1; m < 4; m++) begin
      wait_drained();
      write_config(4, space_t'(m));
      query_pixel(rgba(0, 128, 255, 200));
      query_pixel(rgba(128, 64, 32, 7));
    end

    for (int p = 0; p < 12; p++) begin
      send_idle_pct = (p < 4) ? 15 : (p < 8) ? 79 : 0;
      recv_idle_pct = (p < 4) ? 79 : (p < 8) ? 15 : 0;
      case (p)
        2: cnt = 256;
        5: cnt = 0;
        6: cnt = 511;
        9: cnt = 1;
        10: cnt = $urandom_range(257, 510);
        default: cnt = $urandom_range(2, 24);
      endcase
      run_phase(cnt, space_t'(p % 4), (cnt > 64) ? 15 : 60);
    end

    wait_drained();
    if (sb.errors == 0 && sb.pending_matches.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
